>>> sv/nss_pkg.sv
// Shared types and constants for the name stack with search.
package nss_pkg;

    localparam int NAME_W = 192;
    localparam int POS_W  = 6;

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_LIST   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_OVERFLOW = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_FOUND    = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        SRC_ZERO = 2'd0,
        SRC_NAME = 2'd1,
        SRC_MEM  = 2'd2
    } out_src_t;

    typedef enum logic [2:0] {
        S_IDLE   = 3'd0,
        S_DECODE = 3'd1,
        S_POP    = 3'd2,
        S_SCAN   = 3'd3,
        S_LIST   = 3'd4
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic     latch;
        logic     wr;
        logic     pop;
        logic     advance;
        logic     load;
        status_t  status;
        out_src_t src;
        logic     last;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        cmd_t cmd;
        logic full;
        logic empty;
        logic match;
        logic slot_zero;
        logic can_load;
    } dp_stat_t;

endpackage

>>> sv/nss_ctrl.sv
// Controller state machine for the name stack with search.
module nss_ctrl
    import nss_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.cmd == CMD_PUSH || stat.empty)
                begin
                    if (stat.can_load)
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    case (stat.cmd)
                        CMD_POP:    state_next = S_POP;
                        CMD_SEARCH: state_next = S_SCAN;
                        CMD_LIST:   state_next = S_LIST;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_POP:
            begin
                if (stat.can_load)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if ((stat.match || stat.slot_zero) && stat.can_load)
                begin
                    state_next = S_IDLE;
                end
            end
            S_LIST:
            begin
                if (stat.slot_zero && stat.can_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        cmd         = '0;
        cmd.status  = ST_OK;
        cmd.src     = SRC_ZERO;
        cmd.last    = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.latch = in_valid;
            end
            S_DECODE:
            begin
                if (stat.cmd == CMD_PUSH)
                begin
                    cmd.load = stat.can_load;
                    if (stat.full)
                    begin
                        cmd.status = ST_OVERFLOW;
                    end
                    else
                    begin
                        cmd.src = SRC_NAME;
                        cmd.wr  = stat.can_load;
                    end
                end
                else if (stat.empty)
                begin
                    cmd.load   = stat.can_load;
                    cmd.status = ST_EMPTY;
                end
                else
                begin
                    cmd.advance = 1'b1;
                end
            end
            S_POP:
            begin
                cmd.load = stat.can_load;
                cmd.pop  = stat.can_load;
                cmd.src  = SRC_MEM;
            end
            S_SCAN:
            begin
                if (stat.match)
                begin
                    cmd.load   = stat.can_load;
                    cmd.status = ST_FOUND;
                    cmd.src    = SRC_MEM;
                end
                else if (stat.slot_zero)
                begin
                    cmd.load   = stat.can_load;
                    cmd.status = ST_NOTFOUND;
                end
                else
                begin
                    cmd.advance = 1'b1;
                end
            end
            S_LIST:
            begin
                cmd.load    = stat.can_load;
                cmd.src     = SRC_MEM;
                cmd.last    = stat.slot_zero;
                cmd.advance = stat.can_load && !stat.slot_zero;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> sv/nss_dp.sv
// Datapath for the name stack with search: name store, count, scan pointer, output register.
module nss_dp
    import nss_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  dp_cmd_t           cmd,
    output dp_stat_t          stat,
    input  logic [1:0]        in_cmd,
    input  logic [NAME_W-1:0] in_name,
    output logic              out_valid,
    input  logic              out_ready,
    output status_t           out_status,
    output logic [NAME_W-1:0] out_name,
    output logic [POS_W-1:0]  out_pos,
    output logic              out_last
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [NAME_W-1:0] mem [DEPTH];

    cmd_t              cmd_reg;
    logic [NAME_W-1:0] name_reg;
    logic [NAME_W-1:0] rdata_reg;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic [AW-1:0]     idx_reg;
    logic [AW-1:0]     idx_next;
    logic [AW-1:0]     slot_reg;
    logic              valid_reg;
    logic              valid_next;
    status_t           status_reg;
    logic [NAME_W-1:0] oname_reg;
    logic [POS_W-1:0]  pos_reg;
    logic              last_reg;

    assign stat.cmd       = cmd_reg;
    assign stat.full      = (count_reg >= CW'(DEPTH));
    assign stat.empty     = (count_reg == '0);
    assign stat.match     = (rdata_reg == name_reg);
    assign stat.slot_zero = (slot_reg == '0);
    assign stat.can_load  = !valid_reg || out_ready;

    always_comb
    begin
        count_next = count_reg;
        if (cmd.wr)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.latch)
        begin
            idx_next = AW'(count_reg - 1'b1);
        end
        else if (cmd.advance && idx_reg != '0)
        begin
            idx_next = idx_reg - 1'b1;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            valid_reg <= 1'b0;
            cmd_reg   <= CMD_PUSH;
        end
        else
        begin
            count_reg <= count_next;
            valid_reg <= valid_next;
            if (cmd.latch)
            begin
                cmd_reg <= cmd_t'(in_cmd);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (cmd.latch)
        begin
            name_reg <= in_name;
        end
        if (cmd.advance)
        begin
            slot_reg <= idx_reg;
        end
    end

    // name store
    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            mem[count_reg[AW-1:0]] <= name_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.advance)
        begin
            rdata_reg <= mem[idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            status_reg <= cmd.status;
            last_reg   <= cmd.last;
            case (cmd.src)
                SRC_NAME:
                begin
                    oname_reg <= name_reg;
                    pos_reg   <= POS_W'(count_reg);
                end
                SRC_MEM:
                begin
                    oname_reg <= rdata_reg;
                    pos_reg   <= POS_W'(slot_reg);
                end
                default:
                begin
                    oname_reg <= '0;
                    pos_reg   <= '0;
                end
            endcase
        end
    end

    assign out_valid  = valid_reg;
    assign out_status = status_reg;
    assign out_name   = oname_reg;
    assign out_pos    = pos_reg;
    assign out_last   = last_reg;

endmodule

>>> sv/name_stack_with_search.sv
// Top level of the name stack with push, pop, top-down search and list.
//
//   channel | dir | tdata (low bit up)                          | tuser  | tlast
//   s_*     | in  | name_word0, name_word1, name_word2           | cmd    | -
//   m_*     | out | out_word0, out_word1, out_word2, position, 0 | status | last
//
// One command is in work at a time; s_tready is high only between commands.
// Push and empty answers load in decode, pop in the pop state; search scans top down.
// List gives one beat per cycle while m_tready is high.
// m_tready low holds the walk in place; no beat is dropped or repeated.
// After reset the stack is empty at once; the name store needs no clearing pass.
module name_stack_with_search
    import nss_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [191:0] s_tdata,   // name_word0, name_word1, name_word2
    input  logic [1:0]   s_tuser,   // cmd
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [199:0] m_tdata,   // out_word0, out_word1, out_word2, position, zero pad
    output logic [2:0]   m_tuser,   // status
    output logic         m_tlast    // last
);

    dp_cmd_t           cmd;
    dp_stat_t          stat;
    status_t           out_status;
    logic [NAME_W-1:0] out_name;
    logic [POS_W-1:0]  out_pos;

    nss_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    nss_dp #(
        .DEPTH (DEPTH)
    ) u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_cmd     (s_tuser),
        .in_name    (s_tdata),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (out_status),
        .out_name   (out_name),
        .out_pos    (out_pos),
        .out_last   (m_tlast)
    );

    assign m_tdata = {2'b00, out_pos, out_name};
    assign m_tuser = out_status;

`ifndef SYNTHESIS
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (!m_tvalid || m_tready))
        else $error("result loaded over an unaccepted beat");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr |-> !stat.full)
        else $error("store written while full");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> !stat.empty)
        else $error("pop while empty");

    a_one_at_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second command taken while busy");
`endif

endmodule
